### hdl/tkn_pkg.sv
`default_nettype none

package tkn_pkg;

   // Default widths of the position and length counters.
   localparam int OFFSET_BITS_DEF = 32;
   localparam int LINE_BITS_DEF   = 20;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int LENGTH_BITS_DEF = 16;

   // Depth of the group queue between the scanner and the output stage.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Fixed widths of the token kind and of the character value.
   localparam int KIND_W = 5;
   localparam int CHAR_W = 8;

   // One input byte yields at most this many results.
   localparam int GROUP_SLOTS = 3;
   localparam int GROUP_CNT_W = 2;

   // Token kinds as they appear on the result channel.
   typedef enum logic [KIND_W-1:0] {
      K_LPAREN = 5'd0,
      K_RPAREN = 5'd1,
      K_DOT    = 5'd2,
      K_COMMA  = 5'd3,
      K_SEMI   = 5'd4,
      K_PLUS   = 5'd5,
      K_MINUS  = 5'd6,
      K_STAR   = 5'd7,
      K_SLASH  = 5'd8,
      K_IDENT  = 5'd9,
      K_FALSE  = 5'd10,
      K_TRUE   = 5'd11,
      K_NUMBER = 5'd12,
      K_STRING = 5'd13,
      K_ERROR  = 5'd14,
      K_EOF    = 5'd15,
      K_SBYTE  = 5'd16
   } kind_type;

   // Scanner modes between bytes.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LEAD_DOT,
      MODE_IDENT,
      MODE_NUM_INT,
      MODE_NUM_DOT,
      MODE_NUM_FRAC,
      MODE_STRING,
      MODE_ESCAPE
   } mode_type;

   // Keyword tracker codes: "f" starts false, "t" starts true.
   localparam logic [3:0] KW_NONE       = 4'd0;
   localparam logic [3:0] KW_F_FIRST    = 4'd1;
   localparam logic [3:0] KW_F_LAST     = 4'd4;
   localparam logic [3:0] KW_FALSE_DONE = 4'd5;
   localparam logic [3:0] KW_T_FIRST    = 4'd6;
   localparam logic [3:0] KW_T_LAST     = 4'd8;
   localparam logic [3:0] KW_TRUE_DONE  = 4'd9;

   localparam logic [CHAR_W-1:0] FALSE_TAIL [4] = '{"a", "l", "s", "e"};
   localparam logic [CHAR_W-1:0] TRUE_TAIL  [3] = '{"r", "u", "e"};

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_LOW_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6E;
   localparam logic [CHAR_W-1:0] CH_LOW_T  = 8'h74;

   function automatic logic is_dec_char(input logic [CHAR_W-1:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_head(input logic [CHAR_W-1:0] c);
      return c inside {["a":"z"], ["A":"Z"], "_"};
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
   endfunction

   // Advance the keyword tracker by one identifier byte.
   function automatic logic [3:0] kw_next(input logic [3:0] kp, input logic [CHAR_W-1:0] c);
      logic [3:0] r;
      r = KW_NONE;
      if (kp >= KW_F_FIRST && kp <= KW_F_LAST) begin
         if (c == FALSE_TAIL[2'(kp - KW_F_FIRST)]) begin
            r = kp + 4'd1;
         end
      end else if (kp >= KW_T_FIRST && kp <= KW_T_LAST) begin
         if (c == TRUE_TAIL[2'(kp - KW_T_FIRST)]) begin
            r = kp + 4'd1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/tkn_queue.sv
`default_nettype none

module tkn_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tkn_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data,
   input  wire logic             pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Status and head of the queue.
   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Group storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // A group is never written into a full queue, and the count stays in range.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("group written into a full queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

### hdl/tkn_front.sv
`default_nettype none

module tkn_front #(
   parameter int OFFSET_BITS = tkn_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = tkn_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = tkn_pkg::COLUMN_BITS_DEF,
   parameter int LENGTH_BITS = tkn_pkg::LENGTH_BITS_DEF,
   parameter int GRP_W       = tkn_pkg::GROUP_CNT_W + tkn_pkg::GROUP_SLOTS *
      (tkn_pkg::KIND_W + OFFSET_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS
       + tkn_pkg::CHAR_W)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [tkn_pkg::CHAR_W-1:0] req_ch,
   input  wire logic                     req_end_of_source,
   output logic                          grp_push,
   output logic [GRP_W-1:0]              grp_data,
   input  wire logic                     grp_full
);

   localparam int REC_W = tkn_pkg::KIND_W + OFFSET_BITS + LINE_BITS + COLUMN_BITS
      + LENGTH_BITS + tkn_pkg::CHAR_W;
   localparam int CW    = tkn_pkg::CHAR_W;

   // Scanner state.
   tkn_pkg::mode_type        mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]   offset_ff, offset_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [COLUMN_BITS-1:0]   col_ff, col_in;
   logic [OFFSET_BITS-1:0]   tok_off_ff, tok_off_in;
   logic [LINE_BITS-1:0]     tok_line_ff, tok_line_in;
   logic [COLUMN_BITS-1:0]   tok_col_ff, tok_col_in;
   logic [LENGTH_BITS-1:0]   tok_len_ff, tok_len_in;
   logic [3:0]               kw_ff, kw_in;
   logic                     quote_ff, quote_in;
   logic [OFFSET_BITS-1:0]   dot_off_ff, dot_off_in;
   logic [LINE_BITS-1:0]     dot_line_ff, dot_line_in;
   logic [COLUMN_BITS-1:0]   dot_col_ff, dot_col_in;

   // Result candidates: pending token, held dot, token at the current byte.
   logic                     v0, v1, v2;
   tkn_pkg::kind_type        kind0, kind2, kind_ident;
   logic [LENGTH_BITS-1:0]   len0, len2, len_inc;
   logic [CW-1:0]            cv0;
   logic                     do_idle, begin_tok;
   tkn_pkg::mode_type        begin_mode;
   logic                     accept;
   logic [REC_W-1:0]         rec0, rec1, rec2, slot0, slot1;
   logic [tkn_pkg::GROUP_CNT_W-1:0] grp_cnt;

   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   assign req_ready = !grp_full;
   assign accept    = req_valid && req_ready;

   assign len_inc    = sat_len(tok_len_ff);
   assign kind_ident = (kw_ff == tkn_pkg::KW_FALSE_DONE) ? tkn_pkg::K_FALSE :
                       (kw_ff == tkn_pkg::KW_TRUE_DONE)  ? tkn_pkg::K_TRUE  :
                                                           tkn_pkg::K_IDENT;

   // Classify the byte against the current mode and compute the next state.
   always_comb begin
      mode_in     = mode_ff;
      offset_in   = offset_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      tok_off_in  = tok_off_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_len_in  = tok_len_ff;
      kw_in       = kw_ff;
      quote_in    = quote_ff;
      dot_off_in  = dot_off_ff;
      dot_line_in = dot_line_ff;
      dot_col_in  = dot_col_ff;
      v0          = 1'b0;
      v1          = 1'b0;
      v2          = 1'b0;
      kind0       = tkn_pkg::K_NUMBER;
      kind2       = tkn_pkg::K_ERROR;
      len0        = tok_len_ff;
      len2        = LENGTH_BITS'(1);
      cv0         = '0;
      do_idle     = 1'b0;
      begin_tok   = 1'b0;
      begin_mode  = tkn_pkg::MODE_IDLE;

      if (accept && req_end_of_source) begin
         // End of source flushes the pending token, adds eof, and restarts.
         case (mode_ff)
            tkn_pkg::MODE_LEAD_DOT: begin
               v0    = 1'b1;
               kind0 = tkn_pkg::K_DOT;
            end
            tkn_pkg::MODE_IDENT: begin
               v0    = 1'b1;
               kind0 = kind_ident;
            end
            tkn_pkg::MODE_NUM_INT, tkn_pkg::MODE_NUM_FRAC: begin
               v0    = 1'b1;
               kind0 = tkn_pkg::K_NUMBER;
            end
            tkn_pkg::MODE_NUM_DOT: begin
               v0    = 1'b1;
               v1    = 1'b1;
               kind0 = tkn_pkg::K_NUMBER;
            end
            tkn_pkg::MODE_STRING, tkn_pkg::MODE_ESCAPE: begin
               v0    = 1'b1;
               kind0 = tkn_pkg::K_STRING;
            end
            default: begin
            end
         endcase
         v2          = 1'b1;
         kind2       = tkn_pkg::K_EOF;
         len2        = '0;
         mode_in     = tkn_pkg::MODE_IDLE;
         offset_in   = '0;
         line_in     = LINE_BITS'(1);
         col_in      = COLUMN_BITS'(1);
         tok_off_in  = '0;
         tok_line_in = LINE_BITS'(1);
         tok_col_in  = COLUMN_BITS'(1);
         tok_len_in  = '0;
         kw_in       = tkn_pkg::KW_NONE;
         quote_in    = 1'b0;
         dot_off_in  = '0;
         dot_line_in = LINE_BITS'(1);
         dot_col_in  = COLUMN_BITS'(1);
      end else if (accept) begin
         // Continue or close the token in progress.
         case (mode_ff)
            tkn_pkg::MODE_LEAD_DOT: begin
               if (tkn_pkg::is_dec_char(req_ch)) begin
                  tok_len_in = len_inc;
                  mode_in    = tkn_pkg::MODE_NUM_INT;
               end else begin
                  v0      = 1'b1;
                  kind0   = tkn_pkg::K_DOT;
                  do_idle = 1'b1;
               end
            end
            tkn_pkg::MODE_IDENT: begin
               if (tkn_pkg::is_head(req_ch) || tkn_pkg::is_dec_char(req_ch)) begin
                  tok_len_in = len_inc;
                  kw_in      = tkn_pkg::kw_next(kw_ff, req_ch);
               end else begin
                  v0      = 1'b1;
                  kind0   = kind_ident;
                  do_idle = 1'b1;
               end
            end
            tkn_pkg::MODE_NUM_INT: begin
               if (tkn_pkg::is_dec_char(req_ch)) begin
                  tok_len_in = len_inc;
               end else if (req_ch == tkn_pkg::CH_DOT) begin
                  dot_off_in  = offset_ff;
                  dot_line_in = line_ff;
                  dot_col_in  = col_ff;
                  mode_in     = tkn_pkg::MODE_NUM_DOT;
               end else begin
                  v0      = 1'b1;
                  kind0   = tkn_pkg::K_NUMBER;
                  do_idle = 1'b1;
               end
            end
            tkn_pkg::MODE_NUM_DOT: begin
               if (tkn_pkg::is_dec_char(req_ch)) begin
                  // The held dot and this digit both join the number.
                  tok_len_in = sat_len(len_inc);
                  mode_in    = tkn_pkg::MODE_NUM_FRAC;
               end else begin
                  v0      = 1'b1;
                  v1      = 1'b1;
                  kind0   = tkn_pkg::K_NUMBER;
                  do_idle = 1'b1;
               end
            end
            tkn_pkg::MODE_NUM_FRAC: begin
               if (tkn_pkg::is_dec_char(req_ch)) begin
                  tok_len_in = len_inc;
               end else begin
                  v0      = 1'b1;
                  kind0   = tkn_pkg::K_NUMBER;
                  do_idle = 1'b1;
               end
            end
            tkn_pkg::MODE_STRING: begin
               tok_len_in = len_inc;
               len0       = len_inc;
               if (req_ch == tkn_pkg::CH_BSLASH) begin
                  mode_in = tkn_pkg::MODE_ESCAPE;
               end else if (req_ch == (quote_ff ? tkn_pkg::CH_SQUOTE : tkn_pkg::CH_DQUOTE)) begin
                  v0      = 1'b1;
                  kind0   = tkn_pkg::K_STRING;
                  mode_in = tkn_pkg::MODE_IDLE;
               end else begin
                  v0    = 1'b1;
                  kind0 = tkn_pkg::K_SBYTE;
                  cv0   = req_ch;
               end
            end
            tkn_pkg::MODE_ESCAPE: begin
               tok_len_in = len_inc;
               len0       = len_inc;
               v0         = 1'b1;
               kind0      = tkn_pkg::K_SBYTE;
               cv0        = (req_ch == tkn_pkg::CH_LOW_N) ? tkn_pkg::CH_LF  :
                            (req_ch == tkn_pkg::CH_LOW_T) ? tkn_pkg::CH_TAB : req_ch;
               mode_in    = tkn_pkg::MODE_STRING;
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // Between tokens: punctuation, errors, or the start of a new token.
         if (do_idle) begin
            mode_in = tkn_pkg::MODE_IDLE;
            v2      = 1'b1;
            case (req_ch)
               tkn_pkg::CH_LPAREN: kind2 = tkn_pkg::K_LPAREN;
               tkn_pkg::CH_RPAREN: kind2 = tkn_pkg::K_RPAREN;
               tkn_pkg::CH_COMMA:  kind2 = tkn_pkg::K_COMMA;
               tkn_pkg::CH_SEMI:   kind2 = tkn_pkg::K_SEMI;
               tkn_pkg::CH_PLUS:   kind2 = tkn_pkg::K_PLUS;
               tkn_pkg::CH_MINUS:  kind2 = tkn_pkg::K_MINUS;
               tkn_pkg::CH_STAR:   kind2 = tkn_pkg::K_STAR;
               tkn_pkg::CH_SLASH:  kind2 = tkn_pkg::K_SLASH;
               tkn_pkg::CH_DOT: begin
                  v2         = 1'b0;
                  begin_tok  = 1'b1;
                  begin_mode = tkn_pkg::MODE_LEAD_DOT;
               end
               tkn_pkg::CH_DQUOTE, tkn_pkg::CH_SQUOTE: begin
                  v2         = 1'b0;
                  begin_tok  = 1'b1;
                  begin_mode = tkn_pkg::MODE_STRING;
                  quote_in   = (req_ch == tkn_pkg::CH_SQUOTE);
               end
               default: begin
                  if (tkn_pkg::is_space(req_ch)) begin
                     v2 = 1'b0;
                  end else if (tkn_pkg::is_head(req_ch)) begin
                     v2         = 1'b0;
                     begin_tok  = 1'b1;
                     begin_mode = tkn_pkg::MODE_IDENT;
                     kw_in      = (req_ch == tkn_pkg::CH_LOW_F) ? tkn_pkg::KW_F_FIRST :
                                  (req_ch == tkn_pkg::CH_LOW_T) ? tkn_pkg::KW_T_FIRST :
                                                                  tkn_pkg::KW_NONE;
                  end else if (tkn_pkg::is_dec_char(req_ch)) begin
                     v2         = 1'b0;
                     begin_tok  = 1'b1;
                     begin_mode = tkn_pkg::MODE_NUM_INT;
                  end else begin
                     kind2 = tkn_pkg::K_ERROR;
                  end
               end
            endcase
            if (begin_tok) begin
               tok_off_in  = offset_ff;
               tok_line_in = line_ff;
               tok_col_in  = col_ff;
               tok_len_in  = LENGTH_BITS'(1);
               mode_in     = begin_mode;
            end
         end

         // Position of the next byte.
         offset_in = sat_off(offset_ff);
         if (req_ch == tkn_pkg::CH_LF) begin
            line_in = sat_line(line_ff);
            col_in  = COLUMN_BITS'(1);
         end else begin
            col_in  = sat_col(col_ff);
         end
      end
   end

   // Build the records and pack them in emission order.
   always_comb begin
      rec0 = {kind0, tok_off_ff, tok_line_ff, tok_col_ff, len0, cv0};
      rec1 = {tkn_pkg::K_DOT, dot_off_ff, dot_line_ff, dot_col_ff,
              LENGTH_BITS'(1), CW'(0)};
      rec2 = {kind2, offset_ff, line_ff, col_ff, len2, CW'(0)};
      slot0   = v0 ? rec0 : rec2;
      slot1   = v1 ? rec1 : rec2;
      grp_cnt = tkn_pkg::GROUP_CNT_W'({1'b0, v0}) + tkn_pkg::GROUP_CNT_W'({1'b0, v1})
              + tkn_pkg::GROUP_CNT_W'({1'b0, v2});
   end

   assign grp_data = {grp_cnt, rec2, slot1, slot0};
   assign grp_push = accept && (grp_cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= tkn_pkg::MODE_IDLE;
         offset_ff   <= '0;
         line_ff     <= LINE_BITS'(1);
         col_ff      <= COLUMN_BITS'(1);
         tok_off_ff  <= '0;
         tok_line_ff <= LINE_BITS'(1);
         tok_col_ff  <= COLUMN_BITS'(1);
         tok_len_ff  <= '0;
         kw_ff       <= tkn_pkg::KW_NONE;
         quote_ff    <= 1'b0;
         dot_off_ff  <= '0;
         dot_line_ff <= LINE_BITS'(1);
         dot_col_ff  <= COLUMN_BITS'(1);
      end else begin
         mode_ff     <= mode_in;
         offset_ff   <= offset_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         tok_off_ff  <= tok_off_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         tok_len_ff  <= tok_len_in;
         kw_ff       <= kw_in;
         quote_ff    <= quote_in;
         dot_off_ff  <= dot_off_in;
         dot_line_ff <= dot_line_in;
         dot_col_ff  <= dot_col_in;
      end
   end

   // Line and column are one-based and never wrap to zero.
   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      (line_ff != '0) && (col_ff != '0))
      else $error("line or column reached zero");
   // End of source returns the scanner to the start of a new source.
   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_source) |=> (offset_ff == '0) && (mode_ff == tkn_pkg::MODE_IDLE))
      else $error("scanner did not restart after end of source");

endmodule

`default_nettype wire

### hdl/tkn_back.sv
`default_nettype none

module tkn_back #(
   parameter int OFFSET_BITS = tkn_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = tkn_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = tkn_pkg::COLUMN_BITS_DEF,
   parameter int LENGTH_BITS = tkn_pkg::LENGTH_BITS_DEF,
   parameter int GRP_W       = tkn_pkg::GROUP_CNT_W + tkn_pkg::GROUP_SLOTS *
      (tkn_pkg::KIND_W + OFFSET_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS
       + tkn_pkg::CHAR_W)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      grp_valid,
   input  wire logic [GRP_W-1:0]          grp_data,
   output logic                           grp_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [tkn_pkg::KIND_W-1:0]     rsp_kind,
   output logic [OFFSET_BITS-1:0]         rsp_start_offset,
   output logic [LINE_BITS-1:0]           rsp_start_line,
   output logic [COLUMN_BITS-1:0]         rsp_start_column,
   output logic [LENGTH_BITS-1:0]         rsp_token_length,
   output logic [tkn_pkg::CHAR_W-1:0]     rsp_char_value,
   output logic                           rsp_last_of_run
);

   localparam int CW    = tkn_pkg::CHAR_W;
   localparam int REC_W = tkn_pkg::KIND_W + OFFSET_BITS + LINE_BITS + COLUMN_BITS
      + LENGTH_BITS + CW;
   localparam int CNT_W = tkn_pkg::GROUP_CNT_W;
   localparam int LEN_LO  = CW;
   localparam int COL_LO  = LEN_LO + LENGTH_BITS;
   localparam int LINE_LO = COL_LO + COLUMN_BITS;
   localparam int OFF_LO  = LINE_LO + LINE_BITS;
   localparam int KIND_LO = OFF_LO + OFFSET_BITS;

   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic [REC_W-1:0]               rec_ff, rec_in;
   logic                           last_ff, last_in;
   logic [CNT_W-1:0]               grp_cnt;
   logic [REC_W-1:0]               rec_sel;
   logic                           load, is_last;

   assign grp_cnt = grp_data[GRP_W-1 -: CNT_W];
   assign rec_sel = grp_data[idx_ff * REC_W +: REC_W];
   assign is_last = ((idx_ff + 1'b1) == grp_cnt);

   // Move one record of the head group into the output register per beat.
   always_comb begin
      load     = grp_valid && (!valid_ff || rsp_ready);
      grp_pop  = load && is_last;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rec_in   = rec_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         rec_in   = rec_sel;
         last_in  = is_last;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = rec_ff[KIND_LO +: tkn_pkg::KIND_W];
   assign rsp_start_offset = rec_ff[OFF_LO +: OFFSET_BITS];
   assign rsp_start_line   = rec_ff[LINE_LO +: LINE_BITS];
   assign rsp_start_column = rec_ff[COL_LO +: COLUMN_BITS];
   assign rsp_token_length = rec_ff[LEN_LO +: LENGTH_BITS];
   assign rsp_char_value   = rec_ff[CW-1:0];
   assign rsp_last_of_run  = last_ff;

   // The record index stays inside the head group and rests at zero without one.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      grp_valid |-> (idx_ff < grp_cnt))
      else $error("record index beyond group size");
   a_idx_rest: assert property (@(posedge clock) disable iff (reset)
      !grp_valid |-> (idx_ff == '0))
      else $error("record index left mid-group with queue empty");

endmodule

`default_nettype wire

### hdl/token_scanner.sv
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_ready  ch, end_of_source
// rsp_      out        rsp_valid/rsp_ready  kind, start_offset, start_line, start_column,
//                                           token_length, char_value, last_of_run
//
// One source byte is accepted per cycle while req_ready is high; its results pass the
// group queue and the output register. A byte yielding k results (k at most 3) gives
// k result beats, one per cycle while rsp_ready allows; the queue absorbs the difference.
// req_ready falls only while the group queue holds QUEUE_DEPTH groups.
// Synchronous reset empties the queue and restarts at offset 0, line 1, column 1.

module token_scanner #(
   parameter int OFFSET_BITS = tkn_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = tkn_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = tkn_pkg::COLUMN_BITS_DEF,
   parameter int LENGTH_BITS = tkn_pkg::LENGTH_BITS_DEF,
   parameter int QUEUE_DEPTH = tkn_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [tkn_pkg::CHAR_W-1:0] req_ch,
   input  wire logic                       req_end_of_source,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [tkn_pkg::KIND_W-1:0]      rsp_kind,
   output logic [OFFSET_BITS-1:0]          rsp_start_offset,
   output logic [LINE_BITS-1:0]            rsp_start_line,
   output logic [COLUMN_BITS-1:0]          rsp_start_column,
   output logic [LENGTH_BITS-1:0]          rsp_token_length,
   output logic [tkn_pkg::CHAR_W-1:0]      rsp_char_value,
   output logic                            rsp_last_of_run
);

   localparam int GRP_W = tkn_pkg::GROUP_CNT_W + tkn_pkg::GROUP_SLOTS *
      (tkn_pkg::KIND_W + OFFSET_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS
       + tkn_pkg::CHAR_W);

   logic             push, full, head_valid, pop;
   logic [GRP_W-1:0] push_data, head_data;

   // Scanner: classifies each byte and writes its results as one group.
   tkn_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .GRP_W       (GRP_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_end_of_source (req_end_of_source),
      .grp_push          (push),
      .grp_data          (push_data),
      .grp_full          (full)
   );

   // Group queue between scanner and output stage.
   tkn_queue #(
      .WIDTH (GRP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // Output stage: one result beat per cycle while rsp_ready allows.
   tkn_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .GRP_W       (GRP_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .grp_valid        (head_valid),
      .grp_data         (head_data),
      .grp_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_token_length (rsp_token_length),
      .rsp_char_value   (rsp_char_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

### sim/token_scanner_check.sv
module token_scanner_check
   import tkn_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [CHAR_W-1:0]            req_ch,
   input  wire logic                         req_end_of_source,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [KIND_W-1:0]            rsp_kind,
   input  wire logic [OFFSET_BITS_DEF-1:0]   rsp_start_offset,
   input  wire logic [LINE_BITS_DEF-1:0]     rsp_start_line,
   input  wire logic [COLUMN_BITS_DEF-1:0]   rsp_start_column,
   input  wire logic [LENGTH_BITS_DEF-1:0]   rsp_token_length,
   input  wire logic [CHAR_W-1:0]            rsp_char_value,
   input  wire logic                         rsp_last_of_run,
   output int                                mismatches,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFF_W  = OFFSET_BITS_DEF;
   localparam int LINE_W = LINE_BITS_DEF;
   localparam int COL_W  = COLUMN_BITS_DEF;
   localparam int LEN_W  = LENGTH_BITS_DEF;

   // One result beat as the scanner should present it.
   typedef struct packed {
      kind_type            kind;
      logic [OFF_W-1:0]    offset;
      logic [LINE_W-1:0]   line;
      logic [COL_W-1:0]    column;
      logic [LEN_W-1:0]    length;
      logic [CHAR_W-1:0]   value;
      logic                last;
   } token_beat_type;

   token_beat_type tokens_due[$];
   token_beat_type step_beats[$];
   int             fail_total = 0;

   // Shadow copy of the scanner state.
   mode_type            scan_mode;
   logic [OFF_W-1:0]    byte_pos;
   logic [LINE_W-1:0]   line_no;
   logic [COL_W-1:0]    col_no;
   logic [OFF_W-1:0]    tok_off;
   logic [LINE_W-1:0]   tok_line;
   logic [COL_W-1:0]    tok_col;
   logic [LEN_W-1:0]    tok_len;
   logic [OFF_W-1:0]    dot_off;
   logic [LINE_W-1:0]   dot_line;
   logic [COL_W-1:0]    dot_col;
   logic                single_quote;
   // The last five identifier bytes; word_len stops at six, past any keyword.
   logic [39:0]         word;
   int                  word_len;

   function automatic logic is_decimal(logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_word_head(logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void restart_source();
      scan_mode = MODE_IDLE;
      byte_pos = '0;
      line_no = 1;
      col_no = 1;
      tok_off = '0;
      tok_line = 1;
      tok_col = 1;
      tok_len = '0;
      dot_off = '0;
      dot_line = 1;
      dot_col = 1;
      single_quote = 1'b0;
      word = '0;
      word_len = 0;
   endfunction

   function automatic void emit(kind_type k, logic [OFF_W-1:0] o, logic [LINE_W-1:0] l,
                                logic [COL_W-1:0] cl, logic [LEN_W-1:0] n,
                                logic [CHAR_W-1:0] v);
      token_beat_type b;
      b = '{k, o, l, cl, n, v, 1'b0};
      step_beats.insert(step_beats.size(), b);
   endfunction

   function automatic void emit_token(kind_type k);
      emit(k, tok_off, tok_line, tok_col, tok_len, '0);
   endfunction

   function automatic void bump_length();
      if (!(&tok_len)) tok_len++;
   endfunction

   function automatic void start_token(mode_type m);
      tok_off = byte_pos;
      tok_line = line_no;
      tok_col = col_no;
      tok_len = 1;
      scan_mode = m;
   endfunction

   function automatic kind_type word_kind();
      if (word_len == 5 && word == "false") return K_FALSE;
      if (word_len == 4 && word[31:0] == "true") return K_TRUE;
      return K_IDENT;
   endfunction

   // A byte seen between tokens: punctuation, a token opener, an error, or nothing.
   function automatic void idle_byte(logic [CHAR_W-1:0] c);
      scan_mode = MODE_IDLE;
      case (c)
         CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
         CH_LPAREN: emit(K_LPAREN, byte_pos, line_no, col_no, 1, '0);
         CH_RPAREN: emit(K_RPAREN, byte_pos, line_no, col_no, 1, '0);
         CH_COMMA:  emit(K_COMMA, byte_pos, line_no, col_no, 1, '0);
         CH_SEMI:   emit(K_SEMI, byte_pos, line_no, col_no, 1, '0);
         CH_PLUS:   emit(K_PLUS, byte_pos, line_no, col_no, 1, '0);
         CH_MINUS:  emit(K_MINUS, byte_pos, line_no, col_no, 1, '0);
         CH_STAR:   emit(K_STAR, byte_pos, line_no, col_no, 1, '0);
         CH_SLASH:  emit(K_SLASH, byte_pos, line_no, col_no, 1, '0);
         CH_DOT:    start_token(MODE_LEAD_DOT);
         CH_DQUOTE, CH_SQUOTE: begin
            start_token(MODE_STRING);
            single_quote = (c == CH_SQUOTE);
         end
         default: begin
            if (is_word_head(c)) begin
               start_token(MODE_IDENT);
               word = 40'(c);
               word_len = 1;
            end else if (is_decimal(c)) begin
               start_token(MODE_NUM_INT);
            end else begin
               emit(K_ERROR, byte_pos, line_no, col_no, 1, '0);
            end
         end
      endcase
   endfunction

   // Work out the result beats that one accepted input beat causes.
   function automatic void scan_byte(logic [CHAR_W-1:0] c, logic eos);
      step_beats.delete();
      if (eos) begin
         case (scan_mode)
            MODE_LEAD_DOT: emit_token(K_DOT);
            MODE_IDENT: emit_token(word_kind());
            MODE_NUM_INT, MODE_NUM_FRAC: emit_token(K_NUMBER);
            MODE_NUM_DOT: begin
               emit_token(K_NUMBER);
               emit(K_DOT, dot_off, dot_line, dot_col, 1, '0);
            end
            MODE_STRING, MODE_ESCAPE: emit_token(K_STRING);
            default: ;
         endcase
         emit(K_EOF, byte_pos, line_no, col_no, '0, '0);
         restart_source();
      end else begin
         case (scan_mode)
            MODE_LEAD_DOT: begin
               if (is_decimal(c)) begin
                  bump_length();
                  scan_mode = MODE_NUM_INT;
               end else begin
                  emit_token(K_DOT);
                  idle_byte(c);
               end
            end
            MODE_IDENT: begin
               if (is_word_head(c) || is_decimal(c)) begin
                  bump_length();
                  word = {word[31:0], c};
                  if (word_len < 6) word_len++;
               end else begin
                  emit_token(word_kind());
                  idle_byte(c);
               end
            end
            MODE_NUM_INT: begin
               if (is_decimal(c)) begin
                  bump_length();
               end else if (c == CH_DOT) begin
                  // Hold the dot until the next byte says whether it is a fraction.
                  dot_off = byte_pos;
                  dot_line = line_no;
                  dot_col = col_no;
                  scan_mode = MODE_NUM_DOT;
               end else begin
                  emit_token(K_NUMBER);
                  idle_byte(c);
               end
            end
            MODE_NUM_DOT: begin
               if (is_decimal(c)) begin
                  bump_length();
                  bump_length();
                  scan_mode = MODE_NUM_FRAC;
               end else begin
                  emit_token(K_NUMBER);
                  emit(K_DOT, dot_off, dot_line, dot_col, 1, '0);
                  idle_byte(c);
               end
            end
            MODE_NUM_FRAC: begin
               if (is_decimal(c)) begin
                  bump_length();
               end else begin
                  emit_token(K_NUMBER);
                  idle_byte(c);
               end
            end
            MODE_STRING: begin
               bump_length();
               if (c == CH_BSLASH) begin
                  scan_mode = MODE_ESCAPE;
               end else if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                  emit_token(K_STRING);
                  scan_mode = MODE_IDLE;
               end else begin
                  emit(K_SBYTE, tok_off, tok_line, tok_col, tok_len, c);
               end
            end
            MODE_ESCAPE: begin
               bump_length();
               emit(K_SBYTE, tok_off, tok_line, tok_col, tok_len,
                    c == CH_LOW_N ? CH_LF : (c == CH_LOW_T ? CH_TAB : c));
               scan_mode = MODE_STRING;
            end
            default: idle_byte(c);
         endcase

         // Every byte moves the position; counters hold at their maximum.
         if (!(&byte_pos)) byte_pos++;
         if (c == CH_LF) begin
            if (!(&line_no)) line_no++;
            col_no = 1;
         end else if (!(&col_no)) begin
            col_no++;
         end
      end

      if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) tokens_due.insert(tokens_due.size(), step_beats[i]);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: rsp_%s expected %0d, actual %0d", $time, name, want, got);
         fail_total++;
      end
   endfunction

   // Predict on every request beat, compare every result beat with the oldest prediction.
   always @(posedge clock) begin : watch
      token_beat_type want;
      if (reset) begin
         restart_source();
         tokens_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            scan_byte(req_ch, req_end_of_source);
         end
         if (rsp_valid && rsp_ready) begin
            if (tokens_due.size() == 0) begin
               $display("%0t: rsp beat expected none, actual kind %0d offset %0d length %0d",
                        $time, rsp_kind, rsp_start_offset, rsp_token_length);
               fail_total++;
            end else begin
               want = tokens_due.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("start_offset", want.offset, rsp_start_offset);
               check_field("start_line", want.line, rsp_start_line);
               check_field("start_column", want.column, rsp_start_column);
               check_field("token_length", want.length, rsp_token_length);
               check_field("char_value", want.value, rsp_char_value);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
      end
      mismatches <= fail_total;
      pending <= tokens_due.size();
   end

endmodule

### sim/token_scanner_test.sv
module token_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tkn_pkg::*;

   localparam string DIGITS = "0123456789";
   localparam string HEADS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string TAILS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam string PUNCT  = "(),;+-*/";
   localparam string BLANKS = " \t\r\n";

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [CHAR_W-1:0]            req_ch = '0;
   logic                         req_end_of_source = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [KIND_W-1:0]            rsp_kind;
   logic [OFFSET_BITS_DEF-1:0]   rsp_start_offset;
   logic [LINE_BITS_DEF-1:0]     rsp_start_line;
   logic [COLUMN_BITS_DEF-1:0]   rsp_start_column;
   logic [LENGTH_BITS_DEF-1:0]   rsp_token_length;
   logic [CHAR_W-1:0]            rsp_char_value;
   logic                         rsp_last_of_run;
   int                           mismatches;
   int                           pending;

   int send_gap_pct = 14;
   int take_gap_pct = 83;
   int beats_sent = 0;

   token_scanner i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_start_line    (rsp_start_line),
      .rsp_start_column  (rsp_start_column),
      .rsp_token_length  (rsp_token_length),
      .rsp_char_value    (rsp_char_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   token_scanner_check i_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_start_line    (rsp_start_line),
      .rsp_start_column  (rsp_start_column),
      .rsp_token_length  (rsp_token_length),
      .rsp_char_value    (rsp_char_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_gap_pct);
   end

   function automatic logic [CHAR_W-1:0] pick_char(string pool);
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   // Offer one request beat, maybe after a random gap, and wait for its acceptance.
   task automatic send_beat(input logic [CHAR_W-1:0] c, input logic eos);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_end_of_source <= eos;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // The byte lane of an end marker carries noise.
   task automatic send_eos();
      send_beat(CHAR_W'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_digits(input int count);
      repeat (count) send_beat(pick_char(DIGITS), 1'b0);
   endtask

   // Stop offering beats until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly well-formed tokens with random content, plus noise and end markers.
   task automatic send_random_token();
      string words [8] = '{"false", "true", "fals", "tru", "falsey", "true_", "f", "t"};
      logic [CHAR_W-1:0] quote;
      case ($urandom_range(11))
         0, 1: begin
            send_beat(pick_char(HEADS), 1'b0);
            repeat ($urandom_range(6)) send_beat(pick_char(TAILS), 1'b0);
         end
         2: send_text(words[$urandom_range(7)]);
         3: send_digits($urandom_range(1, 4));
         4: begin
            send_digits($urandom_range(1, 3));
            send_beat(CH_DOT, 1'b0);
            send_digits($urandom_range(1, 3));
         end
         5: begin
            send_beat(CH_DOT, 1'b0);
            if ($urandom_range(1)) send_digits($urandom_range(1, 3));
         end
         6: begin
            // A trailing dot that the next token decides.
            send_digits($urandom_range(1, 3));
            send_beat(CH_DOT, 1'b0);
         end
         7, 8: begin
            quote = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
            send_beat(quote, 1'b0);
            repeat ($urandom_range(6)) begin
               case ($urandom_range(7))
                  0, 1: begin
                     send_beat(CH_BSLASH, 1'b0);
                     case ($urandom_range(2))
                        0: send_beat(CH_LOW_N, 1'b0);
                        1: send_beat(CH_LOW_T, 1'b0);
                        default: send_beat(CHAR_W'($urandom_range(255)), 1'b0);
                     endcase
                  end
                  2: send_beat(CHAR_W'($urandom_range(255)), 1'b0);
                  default: send_beat(CHAR_W'($urandom_range(32, 126)), 1'b0);
               endcase
            end
            if ($urandom_range(7) != 0) send_beat(quote, 1'b0);
         end
         9: send_beat(pick_char(PUNCT), 1'b0);
         10: repeat ($urandom_range(1, 2)) send_beat(pick_char(BLANKS), 1'b0);
         default: begin
            if ($urandom_range(2) == 0) send_eos();
            else send_beat(CHAR_W'($urandom_range(255)), 1'b0);
         end
      endcase
   endtask

   task automatic run_random(input int count);
      int phase_end;
      phase_end = beats_sent + count;
      while (beats_sent < phase_end) send_random_token();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: punctuation, a number whose dot is not a fraction (three
      // results from one byte), both keywords, a line break, an unknown byte,
      // a string with a raw top byte and an escape, a leading-dot number closed
      // by the end marker, and an unterminated string ending in a backslash.
      send_text("(+1.,true;false)\n");
      send_beat(8'h00, 1'b0);
      send_text("'");
      send_beat(8'hFF, 1'b0);
      send_text("\\t'");
      send_text(".5");
      send_eos();
      send_text("\"\\");
      send_eos();
      drain();

      run_random(47);
      drain();

      send_gap_pct = 83;
      take_gap_pct = 14;
      run_random(47);
      drain();

      send_gap_pct = 0;
      take_gap_pct = 0;
      run_random(47);
      send_eos();
      drain();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### token_scanner.f
hdl/tkn_pkg.sv
hdl/tkn_queue.sv
hdl/tkn_front.sv
hdl/tkn_back.sv
hdl/token_scanner.sv
sim/token_scanner_check.sv
sim/token_scanner_test.sv
